[sv/stdpad_pkg.sv]
// shared constants and codes for the stick to d-pad autorepeat block
package stdpad_pkg;

  localparam int AXIS_WIDTH_DEFAULT = 16;

  localparam int MODE_W     = 2;
  localparam int AXIS_ID_W  = 3;
  localparam int VALUE_W    = 16;
  localparam int BUTTON_W   = 4;
  localparam int EVENT_W    = 4;
  localparam int DIR_W      = 3;
  localparam int DZ_W       = 15;
  localparam int TIMER_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 8;

  localparam logic [DZ_W-1:0]    DEADZONE_RESET        = 15'd8000;
  localparam logic [TIMER_W-1:0] INITIAL_DELAY_RESET   = 16'd400;
  localparam logic [TIMER_W-1:0] REPEAT_INTERVAL_RESET = 16'd150;

  localparam logic [MODE_W-1:0] MODE_AXIS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUTTON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  localparam logic [AXIS_ID_W-1:0] AXIS_LEFT_X  = 3'd0;
  localparam logic [AXIS_ID_W-1:0] AXIS_LEFT_Y  = 3'd1;
  localparam logic [AXIS_ID_W-1:0] AXIS_RIGHT_X = 3'd2;
  localparam logic [AXIS_ID_W-1:0] AXIS_RIGHT_Y = 3'd3;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

  localparam logic [BUTTON_W-1:0] BUTTON_MAX = 4'd9;
  localparam logic [EVENT_W-1:0]  EVENT_MAX  = 4'd9;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

endpackage

[sv/stdpad_dir.sv]
// stick direction finder: dominant stick per axis, deadzone, dominant axis
module stdpad_dir #(
  parameter int AXIS_WIDTH = stdpad_pkg::AXIS_WIDTH_DEFAULT
) (
  input  logic [AXIS_WIDTH-1:0]         left_x,
  input  logic [AXIS_WIDTH-1:0]         left_y,
  input  logic [AXIS_WIDTH-1:0]         right_x,
  input  logic [AXIS_WIDTH-1:0]         right_y,
  input  logic [stdpad_pkg::DZ_W-1:0]   deadzone,
  output logic [stdpad_pkg::DIR_W-1:0]  dir
);

  localparam int CW = (AXIS_WIDTH > stdpad_pkg::DZ_W) ? AXIS_WIDTH : stdpad_pkg::DZ_W;

  logic [AXIS_WIDTH-1:0] mag_lx, mag_ly, mag_rx, mag_ry, mag_x, mag_y;
  logic [AXIS_WIDTH-1:0] x, y;
  logic                  x_centered, y_centered, x_pos, y_pos;

  assign mag_lx = left_x[AXIS_WIDTH-1]  ? (~left_x + 1'b1)  : left_x;
  assign mag_ly = left_y[AXIS_WIDTH-1]  ? (~left_y + 1'b1)  : left_y;
  assign mag_rx = right_x[AXIS_WIDTH-1] ? (~right_x + 1'b1) : right_x;
  assign mag_ry = right_y[AXIS_WIDTH-1] ? (~right_y + 1'b1) : right_y;

  // ties go to the right stick
  assign x     = (mag_lx > mag_rx) ? left_x : right_x;
  assign mag_x = (mag_lx > mag_rx) ? mag_lx : mag_rx;
  assign y     = (mag_ly > mag_ry) ? left_y : right_y;
  assign mag_y = (mag_ly > mag_ry) ? mag_ly : mag_ry;

  assign x_centered = CW'(mag_x) <= CW'(deadzone);
  assign y_centered = CW'(mag_y) <= CW'(deadzone);
  assign x_pos      = !x[AXIS_WIDTH-1] && (x != '0);
  assign y_pos      = !y[AXIS_WIDTH-1] && (y != '0);

  always_comb begin
    if (x_centered && y_centered) begin
      dir = stdpad_pkg::DIR_NONE;
    end else if (mag_x >= mag_y) begin
      dir = x_pos ? stdpad_pkg::DIR_RIGHT : stdpad_pkg::DIR_LEFT;
    end else begin
      dir = y_pos ? stdpad_pkg::DIR_DOWN : stdpad_pkg::DIR_UP;
    end
  end

endmodule

[sv/stick_to_dpad_autorepeat.sv]
// top level: stick and button requests to d-pad events with key repeat
// an input register and an output register part the sides, request to event on m_tdata
// throughput: one request per cycle while the output side is not stalled
// a request that gives no event still passes through the input register
// reset: synchronous active-high rst clears axes, direction, timer and handshake state
// and loads deadzone 8000, initial delay 400 and repeat interval 150
module stick_to_dpad_autorepeat #(
  parameter int AXIS_WIDTH = stdpad_pkg::AXIS_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // axis_id [2:0], axis_value [18:3], button_id [22:19], zero [23]
  input  logic [stdpad_pkg::S_DATA_W-1:0]   s_tdata,
  // mode [1:0]
  input  logic [stdpad_pkg::MODE_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // event_code [3:0], zero [7:4]
  output logic [stdpad_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [stdpad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stdpad_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [stdpad_pkg::DZ_W-1:0]    deadzone;
  logic [stdpad_pkg::TIMER_W-1:0] initial_delay;
  logic [stdpad_pkg::TIMER_W-1:0] repeat_interval;

  // input register
  logic                               in_valid;
  logic [stdpad_pkg::MODE_W-1:0]      in_mode;
  logic [stdpad_pkg::AXIS_ID_W-1:0]   in_axis_id;
  logic [stdpad_pkg::VALUE_W-1:0]     in_value;
  logic [stdpad_pkg::BUTTON_W-1:0]    in_button;

  // state
  logic [AXIS_WIDTH-1:0]          left_x, left_y, right_x, right_y;
  logic [stdpad_pkg::DIR_W-1:0]   last_direction, last_direction_next;
  logic                           timer_running, timer_running_next;
  logic [stdpad_pkg::TIMER_W-1:0] timer_count, timer_count_next;
  logic                           fast_phase, fast_phase_next;

  // output register
  logic [stdpad_pkg::EVENT_W-1:0] event_code, event_code_next;
  logic                           has_event;

  logic                           fire;
  logic [stdpad_pkg::DIR_W-1:0]   dir;
  logic [stdpad_pkg::TIMER_W-1:0] limit, count_inc;
  logic                           expire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign m_tdata  = {{(stdpad_pkg::M_DATA_W - stdpad_pkg::EVENT_W){1'b0}}, event_code};

  stdpad_dir #(
    .AXIS_WIDTH (AXIS_WIDTH)
  ) u_dir (
    .left_x   (left_x),
    .left_y   (left_y),
    .right_x  (right_x),
    .right_y  (right_y),
    .deadzone (deadzone),
    .dir      (dir)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone        <= stdpad_pkg::DEADZONE_RESET;
      initial_delay   <= stdpad_pkg::INITIAL_DELAY_RESET;
      repeat_interval <= stdpad_pkg::REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        stdpad_pkg::REG_DEADZONE:        deadzone        <= cfg_data[stdpad_pkg::DZ_W-1:0];
        stdpad_pkg::REG_INITIAL_DELAY:   initial_delay   <= cfg_data;
        stdpad_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode    <= s_tuser;
      in_axis_id <= s_tdata[2:0];
      in_value   <= s_tdata[18:3];
      in_button  <= s_tdata[22:19];
    end
  end

  // repeat timer
  always_comb begin
    limit     = fast_phase ? repeat_interval : initial_delay;
    if (limit == '0) begin
      limit = stdpad_pkg::TIMER_W'(1);
    end
    count_inc = timer_count + 1'b1;
    expire    = count_inc >= limit;
  end

  always_comb begin
    last_direction_next = last_direction;
    timer_running_next  = timer_running;
    timer_count_next    = timer_count;
    fast_phase_next     = fast_phase;
    event_code_next     = event_code;
    has_event           = 1'b0;
    case (in_mode)
      stdpad_pkg::MODE_BUTTON: begin
        if (in_button <= stdpad_pkg::BUTTON_MAX) begin
          has_event       = 1'b1;
          event_code_next = in_button;
        end
      end
      stdpad_pkg::MODE_POLL: begin
        if (dir != last_direction) begin
          last_direction_next = dir;
          timer_count_next    = '0;
          fast_phase_next     = 1'b0;
          timer_running_next  = dir != stdpad_pkg::DIR_NONE;
          has_event           = dir != stdpad_pkg::DIR_NONE;
          event_code_next     = stdpad_pkg::EVENT_W'(dir - 1'b1);
        end
      end
      stdpad_pkg::MODE_TICK: begin
        if (timer_running) begin
          if (!expire) begin
            timer_count_next = count_inc;
          end else begin
            timer_count_next = '0;
            if (dir == stdpad_pkg::DIR_NONE) begin
              timer_running_next  = 1'b0;
              fast_phase_next     = 1'b0;
              last_direction_next = stdpad_pkg::DIR_NONE;
            end else begin
              last_direction_next = dir;
              fast_phase_next     = 1'b1;
              has_event           = 1'b1;
              event_code_next     = stdpad_pkg::EVENT_W'(dir - 1'b1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_x         <= '0;
      left_y         <= '0;
      right_x        <= '0;
      right_y        <= '0;
      last_direction <= stdpad_pkg::DIR_NONE;
      timer_running  <= 1'b0;
      timer_count    <= '0;
      fast_phase     <= 1'b0;
    end else if (fire) begin
      last_direction <= last_direction_next;
      timer_running  <= timer_running_next;
      timer_count    <= timer_count_next;
      fast_phase     <= fast_phase_next;
      if (in_mode == stdpad_pkg::MODE_AXIS) begin
        case (in_axis_id)
          stdpad_pkg::AXIS_LEFT_X:  left_x  <= in_value[AXIS_WIDTH-1:0];
          stdpad_pkg::AXIS_LEFT_Y:  left_y  <= in_value[AXIS_WIDTH-1:0];
          stdpad_pkg::AXIS_RIGHT_X: right_x <= in_value[AXIS_WIDTH-1:0];
          stdpad_pkg::AXIS_RIGHT_Y: right_y <= in_value[AXIS_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= has_event;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_event) begin
      event_code <= event_code_next;
    end
  end

`ifndef SYNTH
  a_idle_count_zero : assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> timer_count == '0)
    else $error("timer count not cleared while stopped");

  a_running_has_dir : assert property (@(posedge clk) disable iff (rst)
    timer_running |-> last_direction != stdpad_pkg::DIR_NONE)
    else $error("repeat timer running with no direction");

  a_idle_slow_phase : assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> !fast_phase)
    else $error("fast phase set while timer stopped");

  a_event_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[stdpad_pkg::EVENT_W-1:0] <= stdpad_pkg::EVENT_MAX)
    else $error("event code out of range");

  a_tick_no_event_idle : assert property (@(posedge clk) disable iff (rst)
    fire && in_mode == stdpad_pkg::MODE_TICK && !timer_running |=> !m_tvalid)
    else $error("event from tick while timer stopped");
`endif

endmodule

[test/dpad_check_pkg.sv]
// event predictor and scoreboard for the stick to d-pad autorepeat testbench
package dpad_check_pkg;
  import stdpad_pkg::*;

  class dpad_event_model;
    logic [DZ_W-1:0]    deadzone;
    logic [TIMER_W-1:0] initial_delay;
    logic [TIMER_W-1:0] repeat_interval;
    int                 left_x, left_y, right_x, right_y;
    logic [DIR_W-1:0]   last_dir;
    bit                 running;
    bit                 fast;
    logic [TIMER_W-1:0] count;
    logic [EVENT_W-1:0] events_due[$];
    int                 requests, useful, checked, errors;

    function new();
      deadzone        = DEADZONE_RESET;
      initial_delay   = INITIAL_DELAY_RESET;
      repeat_interval = REPEAT_INTERVAL_RESET;
      left_x = 0; left_y = 0; right_x = 0; right_y = 0;
      last_dir = DIR_NONE;
      running  = 1'b0;
      fast     = 1'b0;
      count    = '0;
      requests = 0; useful = 0; checked = 0; errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEADZONE:        deadzone = data[DZ_W-1:0];
        REG_INITIAL_DELAY:   initial_delay = data[TIMER_W-1:0];
        REG_REPEAT_INTERVAL: repeat_interval = data[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function int mag(input int v);
      return (v < 0) ? -v : v;
    endfunction

    // right stick wins magnitude ties, x wins the axis tie
    function logic [DIR_W-1:0] stick_direction();
      int x, y;
      x = (mag(left_x) > mag(right_x)) ? left_x : right_x;
      y = (mag(left_y) > mag(right_y)) ? left_y : right_y;
      if (mag(x) <= int'(deadzone) && mag(y) <= int'(deadzone)) return DIR_NONE;
      if (mag(x) >= mag(y)) return (x > 0) ? DIR_RIGHT : DIR_LEFT;
      return (y > 0) ? DIR_DOWN : DIR_UP;
    endfunction

    function void note_request(input logic [MODE_W-1:0] mode,
                               input logic [AXIS_ID_W-1:0] axis_id,
                               input logic signed [VALUE_W-1:0] axis_value,
                               input logic [BUTTON_W-1:0] button_id);
      logic [DIR_W-1:0]   dir;
      logic [TIMER_W-1:0] lim;
      requests++;
      case (mode)
        MODE_AXIS: begin
          if (axis_id <= AXIS_RIGHT_Y) useful++;
          case (axis_id)
            AXIS_LEFT_X:  left_x = int'(axis_value);
            AXIS_LEFT_Y:  left_y = int'(axis_value);
            AXIS_RIGHT_X: right_x = int'(axis_value);
            AXIS_RIGHT_Y: right_y = int'(axis_value);
            default: ;
          endcase
        end
        MODE_BUTTON: begin
          if (button_id <= BUTTON_MAX) begin
            useful++;
            events_due.push_back(EVENT_W'(button_id));
          end
        end
        MODE_POLL: begin
          useful++;
          dir = stick_direction();
          if (dir != last_dir) begin
            last_dir = dir;
            running  = 1'b0;
            count    = '0;
            fast     = 1'b0;
            if (dir != DIR_NONE) begin
              running = 1'b1;
              events_due.push_back(EVENT_W'(dir - DIR_UP));
            end
          end
        end
        default: begin
          if (running) begin
            useful++;
            lim = fast ? repeat_interval : initial_delay;
            if (lim == '0) lim = TIMER_W'(1);
            count = count + 1'b1;
            if (count >= lim) begin
              count = '0;
              dir = stick_direction();
              if (dir == DIR_NONE) begin
                running  = 1'b0;
                fast     = 1'b0;
                last_dir = DIR_NONE;
              end else begin
                last_dir = dir;
                fast     = 1'b1;
                events_due.push_back(EVENT_W'(dir - DIR_UP));
              end
            end
          end
        end
      endcase
    endfunction

    task check_event(input logic [M_DATA_W-1:0] data);
      logic [EVENT_W-1:0] want;
      checked++;
      if (events_due.size() == 0) begin
        report($sformatf("event 0x%02h with none due", data));
      end else begin
        want = events_due.pop_front();
        if (data !== M_DATA_W'(want))
          report($sformatf("event 0x%02h, expected 0x%02h", data, M_DATA_W'(want)));
      end
    endtask
  endclass

endpackage

[test/tb_top.sv]
// top-level testbench for stick_to_dpad_autorepeat
module tb_top;
  import stdpad_pkg::*;
  import dpad_check_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;

  localparam logic [AXIS_ID_W-1:0] AXIS_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dpad_event_model sb = new();
  bit gap_en   = 1'b1;
  bit stall_en = 1'b1;
  int hold_off = 0;
  int idle_cycles = 0;
  int settings = 0;

  stick_to_dpad_autorepeat dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[AXIS_ID_W-1:0], s_tdata[AXIS_ID_W +: VALUE_W],
                        s_tdata[AXIS_ID_W+VALUE_W +: BUTTON_W]);
      if (m_tvalid && m_tready) sb.check_event(m_tdata);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // event sink with random stalls and a requested long hold-off
  initial begin : sink
    int n;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready = 1'b0;
        n = hold_off;
        hold_off = 0;
        repeat (n - 1) @(negedge clk);
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [AXIS_ID_W-1:0] axis_id,
                              input logic [VALUE_W-1:0] axis_value,
                              input logic [BUTTON_W-1:0] button_id);
    @(negedge clk);
    if (gap_en && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = {1'b0, button_id, axis_value, axis_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(data);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, CFG_DATA_W'(data));
    settings++;
  endtask

  task automatic set_timing(input int dz, input int delay, input int interval);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_INITIAL_DELAY, delay);
    write_reg(REG_REPEAT_INTERVAL, interval);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int dz;
    dz = int'(sb.deadzone) + $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      2: return ($urandom_range(0, 1) != 0) ? VALUE_W'(dz) : VALUE_W'(-dz);
      default: return VALUE_W'(int'($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  task automatic axis(input logic [AXIS_ID_W-1:0] id, input int v);
    send_request(MODE_AXIS, id, VALUE_W'(v), BUTTON_W'($urandom));
  endtask

  task automatic poll();
    send_request(MODE_POLL, AXIS_ID_W'($urandom), VALUE_W'($urandom), BUTTON_W'($urandom));
  endtask

  task automatic tick();
    send_request(MODE_TICK, AXIS_ID_W'($urandom), VALUE_W'($urandom), BUTTON_W'($urandom));
  endtask

  task automatic press(input int b);
    send_request(MODE_BUTTON, AXIS_ID_W'($urandom), VALUE_W'($urandom), BUTTON_W'(b));
  endtask

  // mostly stick moves, a poll and a run of ticks; the rest is loose noise
  task automatic random_run(input int n);
    int goal;
    goal = sb.requests + n;
    while (sb.requests < goal) begin
      if ($urandom_range(0, 9) < 6) begin
        repeat ($urandom_range(1, 3))
          send_request(MODE_AXIS, AXIS_ID_W'($urandom_range(0, 3)), pick_value(),
                       BUTTON_W'($urandom));
        poll();
        repeat ($urandom_range(0, 30)) begin
          if ($urandom_range(0, 15) == 0) press($urandom_range(0, 15));
          else if ($urandom_range(0, 15) == 0) poll();
          else tick();
        end
      end else begin
        send_request(MODE_W'($urandom), AXIS_ID_W'($urandom), pick_value(),
                     BUTTON_W'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: centered sticks, buttons, deadzone edges, ties
    poll();
    tick();
    press(0);
    press(9);
    press(10);
    press(15);
    axis(AXIS_UNUSED, 32767);
    axis(AXIS_LEFT_X, -32768);
    poll();
    axis(AXIS_LEFT_X, 20000);
    axis(AXIS_RIGHT_X, -20000);
    poll();
    axis(AXIS_LEFT_X, 0);
    axis(AXIS_RIGHT_X, 8000);
    axis(AXIS_LEFT_Y, 8000);
    poll();
    axis(AXIS_LEFT_Y, 8001);
    poll();
    axis(AXIS_RIGHT_X, -8001);
    poll();
    axis(AXIS_RIGHT_Y, -32768);
    poll();
    tick();
    settle();

    // output held off while buttons keep coming
    hold_off = 60;
    gap_en = 1'b0;
    repeat (12) press($urandom_range(0, 9));
    gap_en = 1'b1;
    settle();

    set_timing(0, 1, 1);
    random_run(100);
    set_timing(32767, 3, 2);
    random_run(60);
    repeat (4) begin
      set_timing($urandom_range(0, 20000), $urandom_range(1, 12), $urandom_range(1, 8));
      random_run(40);
    end

    // initial delay lowered below a running count
    set_timing(8000, 50, 50);
    axis(AXIS_LEFT_X, 0); axis(AXIS_LEFT_Y, 0); axis(AXIS_RIGHT_X, 0); axis(AXIS_RIGHT_Y, 0);
    poll();
    axis(AXIS_LEFT_X, 32767);
    poll();
    repeat (30) tick();
    settle();
    write_reg(REG_INITIAL_DELAY, 4);
    repeat (6) tick();
    settle();

    set_timing(4000, 0, 0);
    random_run(50);
    set_timing(1000, 65535, 65535);
    write_reg(REG_UNUSED, $urandom);
    random_run(30);

    gap_en = 1'b0;
    stall_en = 1'b0;
    set_timing($urandom_range(0, 32767), 2, 1);
    random_run(80);
    repeat (8) @(posedge clk);

    if (sb.events_due.size() != 0)
      sb.report($sformatf("%0d events never arrived", sb.events_due.size()));
    $display("run: %0d requests (%0d effective), %0d events checked, %0d register writes",
             sb.requests, sb.useful, sb.checked, settings);
    $display("stalls and gaps on both sides, one long output hold-off, %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
sv/stdpad_pkg.sv
sv/stdpad_dir.sv
sv/stick_to_dpad_autorepeat.sv
test/dpad_check_pkg.sv
test/tb_top.sv
